/* rtl/cht_pkg.sv */
// coalesced hash table shared package
// types, opcode and status codes, default sizes; no dependencies
package cht_pkg;

	localparam int DEF_TABLE_DEPTH  = 256;
	localparam int DEF_KEY_BITS     = 32;
	localparam int DEF_PAYLOAD_BITS = 32;
	localparam int SIZE_W           = 9;
	localparam int OP_W             = 2;
	localparam int ST_W             = 2;
	localparam int IO_W             = 32;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// control and status handed from the modulo unit back to the sequencer
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} mod_ctl_t;

endpackage

/* rtl/cht_ram.sv */
// generic single-port ram with registered read
// no dependencies
module cht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* rtl/cht_mod.sv */
// restoring remainder unit, one quotient bit per cycle
// uses cht_pkg for the control struct
module cht_mod #(
	parameter int KEY_BITS = cht_pkg::DEF_KEY_BITS,
	parameter int SIZE_W   = cht_pkg::SIZE_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KEY_BITS-1:0] dividend,
	input  logic [SIZE_W-1:0]   divisor,
	output logic [SIZE_W-1:0]   remainder,
	output cht_pkg::mod_ctl_t   ctl
);

	localparam int CNT_W = $clog2(KEY_BITS + 1);

	logic [KEY_BITS-1:0] shift_q;
	logic [SIZE_W:0]     rem_q;
	logic [SIZE_W-1:0]   div_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [SIZE_W+1:0]   trial;
	logic [SIZE_W+1:0]   diff;

	assign trial = {rem_q, shift_q[KEY_BITS-1]};
	assign diff  = trial - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(KEY_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
			div_q   <= divisor;
		end else if (busy_q) begin
			shift_q <= shift_q << 1;
			if (!diff[SIZE_W+1]) begin
				rem_q <= diff[SIZE_W:0];
			end else begin
				rem_q <= trial[SIZE_W:0];
			end
		end
	end

	assign remainder = rem_q[SIZE_W-1:0];
	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;

endmodule

/* rtl/coalesced_hash_table_core.sv */
// coalesced hash table top level: sequencer, slot memories, valid bits
// depends on cht_pkg, cht_ram, cht_mod
//
// one beat in, one beat out. each operation first finds the home slot with a
// bit-serial remainder unit, then walks the chain through single-port slot
// memories, each slot in two states (address, then read), at most
// TABLE_DEPTH slots (TABLE_DEPTH+1 on insert). insert on an occupied home
// slot also scans valid flags for the lowest empty slot, one slot a cycle over
// the active size. in is not ready while an item is in work or its result
// beat waits. valid bits sit in flip-flops cleared by reset, so no clearing
// pass is needed; links of never-valid slots are never followed, since a
// link counts only if the slot it names is valid.
module coalesced_hash_table_core #(
	parameter int TABLE_DEPTH  = cht_pkg::DEF_TABLE_DEPTH,
	parameter int KEY_BITS     = cht_pkg::DEF_KEY_BITS,
	parameter int PAYLOAD_BITS = cht_pkg::DEF_PAYLOAD_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [cht_pkg::OP_W-1:0]  opcode,
	input  logic [cht_pkg::IO_W-1:0]  key,
	input  logic [cht_pkg::IO_W-1:0]  payload,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [cht_pkg::ST_W-1:0]  status,
	output logic [cht_pkg::IO_W-1:0]  found_payload,
	input  logic                      cfg_we,
	input  logic [cht_pkg::SIZE_W-1:0] cfg_wdata
);

	localparam int AW     = $clog2(TABLE_DEPTH);
	localparam int LW     = AW + 1;         // link holds TABLE_DEPTH as null
	localparam int SW     = cht_pkg::SIZE_W;
	localparam int STEP_W = $clog2(TABLE_DEPTH + 1);
	localparam int MODW   = (LW > SW) ? LW : SW;
	localparam logic [LW-1:0] NULL_LINK = LW'(TABLE_DEPTH);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_MOD   = 12'b000000000010,
		S_HOME  = 12'b000000000100,
		S_RD    = 12'b000000001000,
		S_CHK   = 12'b000000010000,
		S_SCAN  = 12'b000000100000,
		S_WNEW  = 12'b000001000000,
		S_WEND  = 12'b000010000000,
		S_NRD   = 12'b000100000000,
		S_NCPY  = 12'b001000000000,
		S_NFREE = 12'b010000000000,
		S_OUT   = 12'b100000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [SW-1:0] table_size_q;
	logic [MODW-1:0] size_act;
	always_comb begin
		if (table_size_q == '0) begin
			size_act = MODW'(1);
		end else if (MODW'(table_size_q) > MODW'(TABLE_DEPTH)) begin
			size_act = MODW'(TABLE_DEPTH);
		end else begin
			size_act = MODW'(table_size_q);
		end
	end

	// captured item
	cht_pkg::op_t          op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	// walk registers
	logic [AW-1:0]   cur_q;
	logic [AW-1:0]   prev_q;
	logic [AW-1:0]   nxt_q;
	logic [AW-1:0]   scan_q;
	logic [STEP_W-1:0] steps_q;
	logic            first_q;
	logic [cht_pkg::ST_W-1:0] st_q;
	logic [cht_pkg::IO_W-1:0] fp_q;

	logic [TABLE_DEPTH-1:0] valid_q;

	// modulo unit, loaded straight from the input beat
	logic                mod_start;
	logic [MODW-1:0]     mod_rem;
	cht_pkg::mod_ctl_t   mod_ctl;

	cht_mod #(.KEY_BITS(KEY_BITS), .SIZE_W(MODW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start),
		.dividend(KEY_BITS'(key)), .divisor(size_act),
		.remainder(mod_rem), .ctl(mod_ctl)
	);

	// slot memories share one address
	logic [AW-1:0]           ram_addr;
	logic                    we_key, we_pay, we_link;
	logic [KEY_BITS-1:0]     wkey, rkey;
	logic [PAYLOAD_BITS-1:0] wpay, rpay;
	logic [LW-1:0]           wlink, rlink;

	cht_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_DEPTH)) u_key (
		.clk(clk), .we(we_key), .addr(ram_addr), .wdata(wkey), .rdata(rkey));
	cht_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(TABLE_DEPTH)) u_pay (
		.clk(clk), .we(we_pay), .addr(ram_addr), .wdata(wpay), .rdata(rpay));
	cht_ram #(.WIDTH(LW), .DEPTH(TABLE_DEPTH)) u_link (
		.clk(clk), .we(we_link), .addr(ram_addr), .wdata(wlink), .rdata(rlink));

	// successor decode of the link just read
	logic          link_ok;
	logic [AW-1:0] link_a;
	assign link_a  = rlink[AW-1:0];
	assign link_ok = (rlink < NULL_LINK) && valid_q[link_a];

	logic scan_last;
	assign scan_last = (MODW'(scan_q) + MODW'(1)) >= size_act;

	logic [AW-1:0] home_a;
	assign home_a = mod_rem[AW-1:0];

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status        = st_q;
	assign found_payload = fp_q;
	assign mod_start = (state_q == S_IDLE) && in_valid;

	// memory port control
	always_comb begin
		ram_addr = cur_q;
		we_key = 1'b0; we_pay = 1'b0; we_link = 1'b0;
		wkey = key_q; wpay = pay_q; wlink = NULL_LINK;
		case (state_q)
			S_WNEW: begin
				ram_addr = scan_q;
				we_key = 1'b1; we_pay = 1'b1; we_link = 1'b1;
			end
			S_WEND: begin
				ram_addr = cur_q;
				we_link = 1'b1;
				wlink = LW'(scan_q);
			end
			S_NRD:   ram_addr = nxt_q;
			S_NCPY: begin
				// nxt_q data now on read ports; copy into chain start
				ram_addr = cur_q;
				we_key = 1'b1; we_pay = 1'b1; we_link = 1'b1;
				wkey = rkey; wpay = rpay; wlink = rlink;
			end
			S_NFREE: begin
				ram_addr = nxt_q;
				we_link = 1'b1;
			end
			S_CHK: begin
				// middle delete: predecessor takes over the link
				if (op_q == cht_pkg::OP_DELETE && rkey == key_q && !first_q) begin
					ram_addr = prev_q;
					we_link = 1'b1;
					wlink = rlink;
				end
			end
			default: ram_addr = cur_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			table_size_q <= SW'(256);
			valid_q      <= '0;
		end else begin
			if (cfg_we) begin
				table_size_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MOD;
				S_MOD: if (mod_ctl.done) state_q <= S_HOME;
				S_HOME: begin
					if (op_q == cht_pkg::OP_NONE) begin
						state_q <= S_OUT;
					end else if (!valid_q[home_a]) begin
						if (op_q == cht_pkg::OP_INSERT) begin
							valid_q[home_a] <= 1'b1;
							state_q <= S_WNEW;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (op_q == cht_pkg::OP_INSERT) begin
						if (link_ok && steps_q != STEP_W'(TABLE_DEPTH)) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_SCAN;
						end
					end else if (rkey == key_q) begin
						if (op_q == cht_pkg::OP_SEARCH) begin
							state_q <= S_OUT;
						end else if (!first_q) begin
							valid_q[cur_q] <= 1'b0;
							state_q <= S_NFREE;
						end else if (link_ok) begin
							state_q <= S_NRD;
						end else begin
							valid_q[cur_q] <= 1'b0;
							state_q <= S_NFREE;
						end
					end else if (link_ok && steps_q != STEP_W'(TABLE_DEPTH - 1)) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_SCAN: begin
					if (!valid_q[scan_q]) begin
						valid_q[scan_q] <= 1'b1;
						state_q <= S_WNEW;
					end else if (scan_last) begin
						state_q <= S_OUT;
					end
				end
				S_WNEW: state_q <= first_q ? S_OUT : S_WEND;
				S_WEND: state_q <= S_OUT;
				S_NRD:  state_q <= S_NCPY;
				S_NCPY: begin
					valid_q[nxt_q] <= 1'b0;
					state_q <= S_NFREE;
				end
				S_NFREE: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q  <= cht_pkg::op_t'(opcode);
				key_q <= KEY_BITS'(key);
				pay_q <= PAYLOAD_BITS'(payload);
				st_q  <= cht_pkg::ST_OK;
				fp_q  <= '0;
			end
			S_HOME: begin
				cur_q   <= home_a;
				prev_q  <= home_a;
				steps_q <= '0;
				first_q <= 1'b1;
				if (op_q != cht_pkg::OP_INSERT && op_q != cht_pkg::OP_NONE &&
				    !valid_q[home_a]) begin
					st_q <= cht_pkg::ST_NOT_FOUND;
				end
				// home slot insert writes at scan address
				scan_q <= (op_q == cht_pkg::OP_INSERT) ? home_a : '0;
			end
			S_RD: begin
				if (op_q == cht_pkg::OP_INSERT) scan_q <= '0;
			end
			S_CHK: begin
				steps_q <= steps_q + 1'b1;
				// slot to free next: the match itself unless its successor moves up
				if (op_q == cht_pkg::OP_DELETE && rkey == key_q &&
				    (!first_q || !link_ok)) begin
					nxt_q <= cur_q;
				end else begin
					nxt_q <= link_a;
				end
				if (op_q == cht_pkg::OP_INSERT) begin
					first_q <= 1'b0;
					if (link_ok && steps_q != STEP_W'(TABLE_DEPTH)) cur_q <= link_a;
				end else if (rkey == key_q) begin
					if (op_q == cht_pkg::OP_SEARCH) begin
						fp_q <= cht_pkg::IO_W'(rpay);
					end
				end else if (link_ok && steps_q != STEP_W'(TABLE_DEPTH - 1)) begin
					prev_q  <= cur_q;
					cur_q   <= link_a;
					first_q <= 1'b0;
				end else begin
					st_q <= cht_pkg::ST_NOT_FOUND;
				end
			end
			S_SCAN: begin
				if (valid_q[scan_q]) begin
					if (scan_last) st_q <= cht_pkg::ST_FULL;
					else scan_q <= scan_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// only one item in work: no input beat while a result waits
	a_no_accept_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted while result pending");
	// remainder unit starts only on an accepted beat
	a_mod_start: assert property (@(posedge clk) disable iff (!arst_n)
		mod_ctl.start |-> (in_valid && in_ready))
		else $error("modulo started without an input beat");
	// a delivered result returns the block to idle
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready)
		else $error("not idle after result beat");
`endif

endmodule
